// ===== rtl/sbm_pkg.sv =====
// ----------------------------------------------------------------------------
// sbm_pkg
// Shared types and constants for the stereo bar meter with peak hold.
// ----------------------------------------------------------------------------
package sbm_pkg;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_PEAK_FALL_STEP = 1'b0,
    REG_BAR_LEVEL      = 1'b1
  } reg_idx_e;

  localparam int unsigned CFG_WIDTH       = 11;
  localparam int unsigned STEP_WIDTH      = 11;
  localparam int unsigned PEAK_WIDTH      = 12;
  localparam int unsigned POS_WIDTH       = 6;
  localparam int unsigned COLOR_WIDTH     = 8;
  localparam int unsigned LEVEL_WIDTH     = 8;
  localparam int unsigned STEP_FRAC_BITS  = 8;

  localparam logic [STEP_WIDTH-1:0]  FALL_STEP_RESET = 11'd111;
  localparam logic [COLOR_WIDTH-1:0] BAR_LEVEL_RESET = 8'd220;
  localparam logic [PEAK_WIDTH-1:0]  PEAK_MAX        = 12'd4095;
  localparam logic [COLOR_WIDTH-1:0] PEAK_RED        = 8'd255;
  localparam logic [COLOR_WIDTH-1:0] TRAIL_RED       = 8'd180;

  // per-frame descriptor handed from front to back
  typedef struct packed {
    logic [POS_WIDTH-1:0] lit_l;
    logic [POS_WIDTH-1:0] lit_r;
    logic [POS_WIDTH-1:0] whole_l;
    logic [POS_WIDTH-1:0] whole_r;
  } frame_t;

  // one output pixel word
  typedef struct packed {
    logic [POS_WIDTH-1:0]   index;
    logic [COLOR_WIDTH-1:0] red;
    logic [COLOR_WIDTH-1:0] green;
    logic [COLOR_WIDTH-1:0] blue;
    logic                   frame_end;
  } pixel_t;

endpackage

// ===== rtl/sbm_fifo.sv =====
// ----------------------------------------------------------------------------
// sbm_fifo
// Two-entry register queue used between the meter stages and at the output.
// ----------------------------------------------------------------------------
module sbm_fifo #(
  parameter int unsigned WIDTH = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (do_pop) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/sbm_front.sv =====
// ----------------------------------------------------------------------------
// sbm_front
// Takes level words, looks up bar lengths and updates the falling peaks.
// ----------------------------------------------------------------------------
module sbm_front #(
  parameter int unsigned LED_COUNT      = 24,
  parameter int unsigned PEAK_FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic [sbm_pkg::LEVEL_WIDTH-1:0]     level_left_i,
  input  logic [sbm_pkg::LEVEL_WIDTH-1:0]     level_right_i,
  input  logic [sbm_pkg::STEP_WIDTH-1:0]      fall_step_i,
  output logic                                frame_push_o,
  output sbm_pkg::frame_t                     frame_o,
  input  logic                                frame_full_i
);

  localparam int unsigned HalfCount = LED_COUNT / 2;
  localparam int unsigned PW = sbm_pkg::POS_WIDTH;
  localparam int unsigned CW = (PW + PEAK_FRAC_BITS > sbm_pkg::PEAK_WIDTH) ?
                               PW + PEAK_FRAC_BITS : sbm_pkg::PEAK_WIDTH;

  logic [PW-1:0] lit_tbl [256];
  logic          s1_valid_q, s1_valid_d;
  logic [PW-1:0] lit_l_q, lit_r_q;
  logic          accept, advance;
  logic [sbm_pkg::PEAK_WIDTH-1:0] peak_l_q, peak_l_d, peak_r_q, peak_r_d;
  logic [CW-1:0] fall;

  // gamma and bar-length table, built at elaboration
  for (genvar v = 0; v < 256; v++) begin : g_lit
    localparam int unsigned Gam = (v * v + 127) / 255;
    localparam int unsigned Lit = Gam * HalfCount / 255;
    assign lit_tbl[v] = PW'(Lit);
  end

  // fall step rescaled to the peak's fraction bits
  if (PEAK_FRAC_BITS >= sbm_pkg::STEP_FRAC_BITS) begin : g_fall_up
    assign fall = CW'(fall_step_i) << (PEAK_FRAC_BITS - sbm_pkg::STEP_FRAC_BITS);
  end else begin : g_fall_dn
    assign fall = CW'(fall_step_i >> (sbm_pkg::STEP_FRAC_BITS - PEAK_FRAC_BITS));
  end

  function automatic logic [sbm_pkg::PEAK_WIDTH-1:0] next_peak(
    input logic [sbm_pkg::PEAK_WIDTH-1:0] peak,
    input logic [PW-1:0]                  lit,
    input logic [CW-1:0]                  fall_amt
  );
    logic [CW-1:0] litf;
    logic [CW-1:0] pk;
    logic [CW-1:0] nxt;
    litf = CW'(lit) << PEAK_FRAC_BITS;
    pk   = CW'(peak);
    if (litf > pk) begin
      nxt = litf;
    end else if (pk > fall_amt) begin
      nxt = pk - fall_amt;
    end else begin
      nxt = '0;
    end
    if (nxt > CW'(sbm_pkg::PEAK_MAX)) begin
      nxt = CW'(sbm_pkg::PEAK_MAX);
    end
    return nxt[sbm_pkg::PEAK_WIDTH-1:0];
  endfunction

  function automatic logic [PW-1:0] peak_whole(
    input logic [sbm_pkg::PEAK_WIDTH-1:0] peak
  );
    logic [sbm_pkg::PEAK_WIDTH-1:0] w;
    w = peak >> PEAK_FRAC_BITS;
    if (w >= sbm_pkg::PEAK_WIDTH'(HalfCount)) begin
      return PW'(HalfCount - 1);
    end
    return w[PW-1:0];
  endfunction

  // stage handshake: stage one drains into the frame queue
  assign advance      = s1_valid_q && !frame_full_i;
  assign full         = s1_valid_q && frame_full_i;
  assign accept       = push && !full;
  assign frame_push_o = s1_valid_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
  end

  // peak update as the frame leaves stage one
  always_comb begin
    peak_l_d = peak_l_q;
    peak_r_d = peak_r_q;
    if (advance) begin
      peak_l_d = next_peak(peak_l_q, lit_l_q, fall);
      peak_r_d = next_peak(peak_r_q, lit_r_q, fall);
    end
  end

  assign frame_o.lit_l   = lit_l_q;
  assign frame_o.lit_r   = lit_r_q;
  assign frame_o.whole_l = peak_whole(next_peak(peak_l_q, lit_l_q, fall));
  assign frame_o.whole_r = peak_whole(next_peak(peak_r_q, lit_r_q, fall));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      peak_l_q   <= '0;
      peak_r_q   <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      peak_l_q   <= peak_l_d;
      peak_r_q   <= peak_r_d;
    end
  end

  // bar lengths of the accepted word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lit_l_q <= lit_tbl[level_left_i];
      lit_r_q <= lit_tbl[level_right_i];
    end
  end

endmodule

// ===== rtl/sbm_back.sv =====
// ----------------------------------------------------------------------------
// sbm_back
// Pixel sequencer: walks the strip once per frame, one pixel per cycle unless stalled.
// ----------------------------------------------------------------------------
module sbm_back #(
  parameter int unsigned LED_COUNT = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sbm_pkg::frame_t                   frame_i,
  input  logic                              frame_empty_i,
  output logic                              frame_pop_o,
  input  logic [sbm_pkg::COLOR_WIDTH-1:0]   bar_level_i,
  output logic                              pixel_push_o,
  output sbm_pkg::pixel_t                   pixel_o,
  input  logic                              pixel_full_i
);

  localparam int unsigned HalfCount = LED_COUNT / 2;
  localparam int unsigned PW = sbm_pkg::POS_WIDTH;

  logic [PW-1:0] cursor_q, cursor_d;
  logic          step, last;
  logic          in_left, in_right;
  logic [PW-1:0] pos, lit, whole;
  logic [PW:0]   trail;

  assign step         = !frame_empty_i && !pixel_full_i;
  assign last         = (cursor_q == PW'(LED_COUNT - 1));
  assign frame_pop_o  = step && last;
  assign pixel_push_o = step;

  // cursor walk
  always_comb begin
    cursor_d = cursor_q;
    if (step) begin
      cursor_d = last ? '0 : cursor_q + PW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
    end else begin
      cursor_q <= cursor_d;
    end
  end

  // half select
  assign in_left  = (cursor_q < PW'(HalfCount));
  assign in_right = !in_left && ((PW + 1)'(cursor_q) < (PW + 1)'(2 * HalfCount));
  assign pos      = in_left ? cursor_q : cursor_q - PW'(HalfCount);
  assign lit      = in_left ? frame_i.lit_l : frame_i.lit_r;
  assign whole    = in_left ? frame_i.whole_l : frame_i.whole_r;
  assign trail    = (PW + 1)'(whole) + (PW + 1)'(1);

  // pixel colour with the peak drawn over the bar
  always_comb begin
    pixel_o.index     = cursor_q;
    pixel_o.frame_end = last;
    pixel_o.red       = '0;
    pixel_o.green     = '0;
    pixel_o.blue      = '0;
    if (in_left || in_right) begin
      if (pos < lit) begin
        pixel_o.red   = bar_level_i;
        pixel_o.green = bar_level_i;
        pixel_o.blue  = bar_level_i;
      end
      if (whole != '0) begin
        if (pos == whole) begin
          pixel_o.red   = sbm_pkg::PEAK_RED;
          pixel_o.green = '0;
          pixel_o.blue  = '0;
        end else if (((PW + 1)'(pos) == trail) &&
                     (trail < (PW + 1)'(HalfCount))) begin
          pixel_o.red   = sbm_pkg::TRAIL_RED;
          pixel_o.green = '0;
          pixel_o.blue  = '0;
        end
      end
    end
  end

endmodule

// ===== rtl/stereo_bar_meter_peak_hold.sv =====
// ----------------------------------------------------------------------------
// stereo_bar_meter_peak_hold
// Stereo LED bar meter with falling peak hold, one pixel word per cycle unless stalled.
// ----------------------------------------------------------------------------
// First pixel of a frame is poppable once its level word has passed the
// stage-one register, the frame queue and the pixel queue. The sequencer
// emits one pixel per cycle unless stalled; a new level word is taken while
// the previous frame is still being drawn (two-frame queue in between).
// Reset clears the peaks, the cursor and both queues; the fall step resets
// to 111 (Q.8) and the bar level to 220.
module stereo_bar_meter_peak_hold #(
  parameter int unsigned LED_COUNT      = 24,
  parameter int unsigned PEAK_FRAC_BITS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // level words
  input  logic                              push,
  output logic                              full,
  input  logic [sbm_pkg::LEVEL_WIDTH-1:0]   level_left_i,
  input  logic [sbm_pkg::LEVEL_WIDTH-1:0]   level_right_i,
  // pixel words
  output logic                              empty,
  input  logic                              pop,
  output logic [sbm_pkg::POS_WIDTH-1:0]     pixel_index_o,
  output logic [sbm_pkg::COLOR_WIDTH-1:0]   red_o,
  output logic [sbm_pkg::COLOR_WIDTH-1:0]   green_o,
  output logic [sbm_pkg::COLOR_WIDTH-1:0]   blue_o,
  output logic                              frame_end_o,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [0:0]                        cfg_idx_i,
  input  logic [sbm_pkg::CFG_WIDTH-1:0]     cfg_wdata_i
);

  logic [sbm_pkg::STEP_WIDTH-1:0]  fall_step_q;
  logic [sbm_pkg::COLOR_WIDTH-1:0] bar_level_q;

  logic            frame_push, frame_full, frame_pop, frame_empty;
  sbm_pkg::frame_t frame_in, frame_out;
  logic            pixel_push, pixel_full;
  sbm_pkg::pixel_t pixel_in, pixel_out;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fall_step_q <= sbm_pkg::FALL_STEP_RESET;
      bar_level_q <= sbm_pkg::BAR_LEVEL_RESET;
    end else if (cfg_we_i) begin
      unique case (sbm_pkg::reg_idx_e'(cfg_idx_i))
        sbm_pkg::REG_PEAK_FALL_STEP: fall_step_q <= cfg_wdata_i[sbm_pkg::STEP_WIDTH-1:0];
        sbm_pkg::REG_BAR_LEVEL:      bar_level_q <= cfg_wdata_i[sbm_pkg::COLOR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // front: bar lengths and peaks
  sbm_front #(
    .LED_COUNT      (LED_COUNT),
    .PEAK_FRAC_BITS (PEAK_FRAC_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .level_left_i  (level_left_i),
    .level_right_i (level_right_i),
    .fall_step_i   (fall_step_q),
    .frame_push_o  (frame_push),
    .frame_o       (frame_in),
    .frame_full_i  (frame_full)
  );

  // frame queue between front and back
  sbm_fifo #(
    .WIDTH ($bits(sbm_pkg::frame_t))
  ) u_frame_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (frame_push),
    .wdata_i (frame_in),
    .full_o  (frame_full),
    .pop_i   (frame_pop),
    .rdata_o (frame_out),
    .empty_o (frame_empty)
  );

  // back: pixel sequencer
  sbm_back #(
    .LED_COUNT (LED_COUNT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_i       (frame_out),
    .frame_empty_i (frame_empty),
    .frame_pop_o   (frame_pop),
    .bar_level_i   (bar_level_q),
    .pixel_push_o  (pixel_push),
    .pixel_o       (pixel_in),
    .pixel_full_i  (pixel_full)
  );

  // output queue
  sbm_fifo #(
    .WIDTH ($bits(sbm_pkg::pixel_t))
  ) u_pixel_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (pixel_push),
    .wdata_i (pixel_in),
    .full_o  (pixel_full),
    .pop_i   (pop),
    .rdata_o (pixel_out),
    .empty_o (empty)
  );

  assign pixel_index_o = pixel_out.index;
  assign red_o         = pixel_out.red;
  assign green_o       = pixel_out.green;
  assign blue_o        = pixel_out.blue;
  assign frame_end_o   = pixel_out.frame_end;

endmodule
